// ===== src/tlpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlpt_pkg;

  localparam int TABLE_COUNT       = 64;
  localparam int ENTRIES_PER_TABLE = 1024;

  localparam int DIR_DEPTH  = 1024;
  localparam int DIR_IDX_W  = $clog2(DIR_DEPTH);
  localparam int SLOT_W     = $clog2(ENTRIES_PER_TABLE);
  localparam int TBL_IDX_W  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int TBL_ADDR_W = TBL_IDX_W + SLOT_W;
  localparam int NFT_W      = $clog2(TABLE_COUNT + 1);
  localparam int ENTRY_W    = 32;
  localparam int PAGE_W     = 20;
  localparam int PHYS_W     = 40;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_NOT_PRESENT = 3'd1,
    STATUS_NO_LARGE    = 3'd2,
    STATUS_PRESENT     = 3'd3,
    STATUS_NO_TABLE    = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PSE36      = 2'd0,
    CFG_MAX_PHYS   = 2'd1,
    CFG_TABLE_BASE = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR_CHK,
    ST_TBL_CHK,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic        command;
    logic [31:0] linear_address;
    logic [39:0] phys_address;
    logic        writable;
    logic        user_access;
    logic        write_through;
    logic        cache_disable;
    logic        large_page;
    logic        global_page;
    logic        attribute_table;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [39:0] phys_out;
  } result_t;

endpackage

`default_nettype wire

// ===== src/tlpt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlpt_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/two_level_page_table_map_walk_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Page directory and page table pool with a translate/map sequencer. After reset the block
// clears the 1024-entry directory, one entry a cycle, holding busy high meanwhile;
// configuration writes are taken throughout. A word is taken when start is high and busy is
// low; its result shows on result for the single cycle that done is high, and the receiver
// cannot stall it. Every answer decided from the directory entry alone (a 4 MB walk, a
// directory miss, any 4 MB map, a directory refusal) is set in the directory check state;
// a walk or map through a 4 KB table goes on to the table check state. A small map that
// allocates a table sweeps its 1024 entries, writing the new entry on the way, and answers
// as the sweep ends. busy falls in the cycle done rises, so a new word may be taken then.
// Each step is set by the registered read of the directory and then of the table memory,
// with one shared subtract and compare turning a directory link into a pool table number.
module two_level_page_table_map_walk_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire tlpt_pkg::request_t                  request,
  output logic                                     done,
  output tlpt_pkg::result_t                        result,
  input  wire logic                                cfg_write_enable,
  input  wire logic [tlpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tlpt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tlpt_pkg::state_t   state, state_next;
  tlpt_pkg::request_t req_q;
  tlpt_pkg::result_t  result_next;
  logic               done_next;

  logic [tlpt_pkg::SLOT_W-1:0]    cnt, cnt_next;
  logic [tlpt_pkg::TBL_IDX_W-1:0] tbl_q, tbl_next;
  logic [tlpt_pkg::NFT_W-1:0]     nft, nft_next;

  logic                        pse36_enable;
  logic [5:0]                  max_phys_bits;
  logic [tlpt_pkg::PAGE_W-1:0] table_base_page;

  logic                                dir_we;
  logic [tlpt_pkg::DIR_IDX_W-1:0]      dir_waddr, dir_raddr;
  logic [tlpt_pkg::ENTRY_W-1:0]        dir_wdata, dir_rdata;
  logic                                tbl_we;
  logic [tlpt_pkg::TBL_ADDR_W-1:0]     tbl_waddr, tbl_raddr;
  logic [tlpt_pkg::ENTRY_W-1:0]        tbl_wdata, tbl_rdata;

  logic [tlpt_pkg::PAGE_W-1:0] link_t;
  logic                        link_ok;
  logic [3:0]                  kept_bits;
  logic [7:0]                  high_mask;
  logic [7:0]                  high_bits;
  logic [4:0]                  flags;
  logic [tlpt_pkg::ENTRY_W-1:0] large_entry, small_entry, link_entry;
  logic [tlpt_pkg::SLOT_W-1:0]  slot;
  logic                         misaligned;

  assign busy = (state != tlpt_pkg::ST_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pse36_enable    <= 1'b0;
      max_phys_bits   <= 6'd32;
      table_base_page <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        tlpt_pkg::CFG_PSE36:      pse36_enable    <= cfg_data[0];
        tlpt_pkg::CFG_MAX_PHYS:   max_phys_bits   <= cfg_data[5:0];
        tlpt_pkg::CFG_TABLE_BASE: table_base_page <= cfg_data;
        default: ;
      endcase
    end
  end

  tlpt_ram #(.ADDR_W(tlpt_pkg::DIR_IDX_W), .DATA_W(tlpt_pkg::ENTRY_W)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  tlpt_ram #(.ADDR_W(tlpt_pkg::TBL_ADDR_W), .DATA_W(tlpt_pkg::ENTRY_W)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // shared link check: pool table number from a directory link
  assign link_t  = dir_rdata[31:12] - table_base_page;
  assign link_ok = (link_t < tlpt_pkg::PAGE_W'(tlpt_pkg::TABLE_COUNT));

  // physical width clamped to 32..40, high bits kept for pse-36
  always_comb begin
    if (max_phys_bits > 6'd40) begin
      kept_bits = 4'd8;
    end else if (max_phys_bits < 6'd32) begin
      kept_bits = 4'd0;
    end else begin
      kept_bits = 4'(max_phys_bits - 6'd32);
    end
  end

  assign high_mask = 8'((9'd1 << kept_bits) - 9'd1);
  assign high_bits = pse36_enable ? (req_q.phys_address[39:32] & high_mask) : 8'd0;

  assign flags = {req_q.cache_disable, req_q.write_through, req_q.user_access,
                  req_q.writable, 1'b1};
  assign slot  = req_q.linear_address[21:12];

  assign misaligned = (req_q.linear_address[21:0] != 22'd0) ||
                      (req_q.phys_address[21:0] != 22'd0);

  assign large_entry = {req_q.phys_address[31:22], 1'b0, high_bits, req_q.attribute_table,
                        3'b000, req_q.global_page, 1'b1, 2'b00, flags};
  assign small_entry = {req_q.phys_address[31:12], 3'b000, req_q.global_page,
                        req_q.attribute_table, 2'b00, flags};
  assign link_entry  = {table_base_page + tlpt_pkg::PAGE_W'(nft), 7'd0, flags};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlpt_pkg::ST_CLEAR;
      cnt   <= '0;
      nft   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      nft   <= nft_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    tbl_q  <= tbl_next;
    result <= result_next;
    if (start && !busy) begin
      req_q <= request;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    tbl_next    = tbl_q;
    nft_next    = nft;
    done_next   = 1'b0;
    result_next = result;

    dir_we    = 1'b0;
    dir_waddr = req_q.linear_address[31:22];
    dir_wdata = '0;
    dir_raddr = request.linear_address[31:22];
    tbl_we    = 1'b0;
    tbl_waddr = {tbl_q, cnt};
    tbl_wdata = '0;
    tbl_raddr = {link_t[tlpt_pkg::TBL_IDX_W-1:0], slot};

    case (state)
      tlpt_pkg::ST_CLEAR: begin
        dir_we    = 1'b1;
        dir_waddr = cnt;
        cnt_next  = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = tlpt_pkg::ST_IDLE;
        end
      end

      tlpt_pkg::ST_IDLE: begin
        if (start) begin
          state_next = tlpt_pkg::ST_DIR_CHK;
        end
      end

      tlpt_pkg::ST_DIR_CHK: begin
        state_next         = tlpt_pkg::ST_IDLE;
        done_next          = 1'b1;
        result_next.phys_out = '0;
        result_next.status   = tlpt_pkg::STATUS_OK;
        tbl_next           = link_t[tlpt_pkg::TBL_IDX_W-1:0];
        if (!req_q.command) begin
          if (!dir_rdata[0]) begin
            result_next.status = tlpt_pkg::STATUS_NOT_PRESENT;
          end else if (dir_rdata[7]) begin
            result_next.phys_out = {dir_rdata[20:13], dir_rdata[31:22],
                                    req_q.linear_address[21:0]};
          end else if (!link_ok) begin
            result_next.status = tlpt_pkg::STATUS_NOT_PRESENT;
          end else begin
            state_next = tlpt_pkg::ST_TBL_CHK;
            done_next  = 1'b0;
          end
        end else if (req_q.large_page) begin
          if (dir_rdata[0] || misaligned) begin
            result_next.status = tlpt_pkg::STATUS_NO_LARGE;
          end else begin
            dir_we    = 1'b1;
            dir_wdata = large_entry;
          end
        end else if (!dir_rdata[0]) begin
          if (nft >= tlpt_pkg::NFT_W'(tlpt_pkg::TABLE_COUNT)) begin
            result_next.status = tlpt_pkg::STATUS_NO_TABLE;
          end else begin
            // link the next free table, then sweep it clear
            dir_we     = 1'b1;
            dir_wdata  = link_entry;
            tbl_next   = nft[tlpt_pkg::TBL_IDX_W-1:0];
            nft_next   = nft + 1'b1;
            cnt_next   = '0;
            state_next = tlpt_pkg::ST_SWEEP;
            done_next  = 1'b0;
          end
        end else if (dir_rdata[7]) begin
          result_next.status = tlpt_pkg::STATUS_PRESENT;
        end else if (!link_ok) begin
          result_next.status = tlpt_pkg::STATUS_NO_TABLE;
        end else begin
          state_next = tlpt_pkg::ST_TBL_CHK;
          done_next  = 1'b0;
        end
      end

      tlpt_pkg::ST_TBL_CHK: begin
        state_next           = tlpt_pkg::ST_IDLE;
        done_next            = 1'b1;
        result_next.phys_out = '0;
        result_next.status   = tlpt_pkg::STATUS_OK;
        if (!tbl_rdata[0]) begin
          if (req_q.command) begin
            tbl_we    = 1'b1;
            tbl_waddr = {tbl_q, slot};
            tbl_wdata = small_entry;
          end else begin
            result_next.status = tlpt_pkg::STATUS_NOT_PRESENT;
          end
        end else if (req_q.command) begin
          result_next.status = tlpt_pkg::STATUS_PRESENT;
        end else begin
          result_next.phys_out = {8'd0, tbl_rdata[31:12], req_q.linear_address[11:0]};
        end
      end

      tlpt_pkg::ST_SWEEP: begin
        // new entry lands in its slot during the clearing pass
        tbl_we    = 1'b1;
        tbl_wdata = (cnt == slot) ? small_entry : '0;
        cnt_next  = cnt + 1'b1;
        if (cnt == '1) begin
          state_next           = tlpt_pkg::ST_IDLE;
          done_next            = 1'b1;
          result_next.status   = tlpt_pkg::STATUS_OK;
          result_next.phys_out = '0;
        end
      end

      default: begin
        state_next = tlpt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tlpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlpt_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire tlpt_pkg::result_t result
);

  // a result only follows a cycle of work
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result word without preceding work");

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> !done)
    else $error("result word one cycle after acceptance");

  assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != tlpt_pkg::STATUS_OK)) |-> (result.phys_out == '0))
    else $error("failed result carries an address");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= tlpt_pkg::STATUS_NO_TABLE))
    else $error("status code out of range");

endmodule

bind two_level_page_table_map_walk_unit tlpt_checker u_tlpt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// ===== dv/tb_two_level_page_table_map_walk_unit.sv =====
`timescale 1ns / 1ps

module tb_two_level_page_table_map_walk_unit;
  import tlpt_pkg::*;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_MAP       = 1'b1;

  // attribute bits in request order: rw, us, pwt, pcd, ps, g, pat
  localparam logic [6:0] A_NONE      = 7'h00;
  localparam logic [6:0] A_LARGE     = 7'h04;
  localparam logic [6:0] A_ALL       = 7'h7F;
  localparam logic [6:0] A_SMALL_ALL = 7'h7B;
  localparam logic [6:0] A_MIXED     = 7'h5A;

  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int RANDOM_PER_PASS = 160;
  localparam int HOT_SLOTS       = 48;
  localparam int DIRECTED_ROWS   = 21;

  typedef struct packed {
    logic        cmd;
    logic [31:0] lin;
    logic [39:0] pa;
    logic [6:0]  attr;
    logic        typed;
    status_t     st;
    logic [39:0] phys;
  } stim_row_t;

  // directed rows assume pse36 on, 40-bit width and pool base 0xFFFFF
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_TRANSLATE, 32'h0000_0000, 40'h00_0000_0000, A_NONE, 1'b1,
      STATUS_NOT_PRESENT, 40'h0},
    '{CMD_TRANSLATE, 32'hFFFF_FFFF, 40'h00_0000_0000, A_NONE, 1'b1,
      STATUS_NOT_PRESENT, 40'h0},
    '{CMD_MAP, 32'hFFC0_0000, 40'hFF_FFC0_0000, A_ALL, 1'b1, STATUS_OK, 40'h0},
    '{CMD_TRANSLATE, 32'hFFFF_FFFF, 40'h00_0000_0000, A_NONE, 1'b1,
      STATUS_OK, 40'hFF_FFFF_FFFF},
    '{CMD_MAP, 32'hFFC0_0000, 40'h00_0000_0000, A_LARGE, 1'b1, STATUS_NO_LARGE, 40'h0},
    '{CMD_MAP, 32'h0040_0001, 40'h00_0000_0000, A_LARGE, 1'b1, STATUS_NO_LARGE, 40'h0},
    '{CMD_MAP, 32'h0040_0000, 40'h00_0020_0000, A_LARGE, 1'b1, STATUS_NO_LARGE, 40'h0},
    '{CMD_TRANSLATE, 32'h0040_0000, 40'h00_0000_0000, A_NONE, 1'b1,
      STATUS_NOT_PRESENT, 40'h0},
    '{CMD_MAP, 32'hFFC0_1000, 40'h00_0000_1000, A_NONE, 1'b1, STATUS_PRESENT, 40'h0},
    '{CMD_MAP, 32'h0000_0000, 40'hFF_FFFF_FFFF, A_SMALL_ALL, 1'b1, STATUS_OK, 40'h0},
    '{CMD_TRANSLATE, 32'h0000_0FFF, 40'h00_0000_0000, A_NONE, 1'b1,
      STATUS_OK, 40'h00_FFFF_FFFF},
    '{CMD_MAP, 32'h0000_0000, 40'h00_0000_0000, A_NONE, 1'b1, STATUS_PRESENT, 40'h0},
    '{CMD_TRANSLATE, 32'h0000_1000, 40'h00_0000_0000, A_NONE, 1'b1,
      STATUS_NOT_PRESENT, 40'h0},
    '{CMD_MAP, 32'h0000_1234, 40'h12_3456_7ABC, A_NONE, 1'b1, STATUS_OK, 40'h0},
    '{CMD_TRANSLATE, 32'h0000_1ABC, 40'h00_0000_0000, A_NONE, 1'b1,
      STATUS_OK, 40'h00_3456_7ABC},
    '{CMD_MAP, 32'h0000_0000, 40'h00_0000_0000, A_LARGE, 1'b1, STATUS_NO_LARGE, 40'h0},
    '{CMD_MAP, 32'h0080_0000, 40'h3C_0040_0000, A_LARGE, 1'b1, STATUS_OK, 40'h0},
    '{CMD_TRANSLATE, 32'h00BF_FFFF, 40'h00_0000_0000, A_NONE, 1'b1,
      STATUS_OK, 40'h3C_007F_FFFF},
    '{CMD_TRANSLATE, 32'h0000_2000, 40'hFF_FFFF_FFFF, A_ALL, 1'b1,
      STATUS_NOT_PRESENT, 40'h0},
    '{CMD_MAP, 32'h3FFF_F000, 40'h00_ABCD_E000, A_MIXED, 1'b0, STATUS_OK, 40'h0},
    '{CMD_TRANSLATE, 32'h3FFF_FFFF, 40'h00_0000_0000, A_NONE, 1'b0, STATUS_OK, 40'h0}
  };

  localparam int          PASS_IDLE [4] = '{32, 80, 0, 0};
  localparam logic        PASS_PSE  [4] = '{1'b1, 1'b0, 1'b1, 1'b1};
  localparam logic [5:0]  PASS_WIDE [4] = '{6'd40, 6'd32, 6'd63, 6'd35};
  localparam logic [19:0] PASS_STEP [4] = '{20'd0, 20'd1, 20'd3, 20'd200};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t request = '0;
  logic done;
  result_t result;
  logic cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // mirror of the block state
  logic [31:0] dir_mirror [DIR_DEPTH];
  logic [31:0] tbl_mirror [TABLE_COUNT*ENTRIES_PER_TABLE];
  int unsigned tables_used;
  logic        pse_on;
  logic [5:0]  phys_width;
  logic [19:0] pool_base;

  result_t     answers_due [$];
  logic [32:0] mapped_lins [$];
  logic [9:0]  hot_dir [HOT_SLOTS];
  int          fail_count = 0;
  int          quiet_cycles = 0;

  two_level_page_table_map_walk_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // works out the answer to one word and updates the mirror as the block would
  function automatic result_t walk_or_map(input request_t rq);
    result_t     ans;
    logic [31:0] de;
    logic [31:0] te;
    logic [31:0] flags;
    logic [19:0] tnum;
    logic [7:0]  high;
    logic [8:0]  keep;
    int          m;
    int          slot;
    ans.status = STATUS_OK;
    ans.phys_out = '0;
    de = dir_mirror[rq.linear_address[31:22]];
    tnum = de[31:12] - pool_base;
    flags = {27'd0, rq.cache_disable, rq.write_through, rq.user_access, rq.writable, 1'b1};
    if (rq.command == CMD_TRANSLATE) begin
      if (!de[0]) begin
        ans.status = STATUS_NOT_PRESENT;
      end else if (de[7]) begin
        ans.phys_out = {de[20:13], de[31:22], rq.linear_address[21:0]};
      end else if (tnum >= TABLE_COUNT) begin
        ans.status = STATUS_NOT_PRESENT;
      end else begin
        te = tbl_mirror[int'(tnum)*ENTRIES_PER_TABLE + int'(rq.linear_address[21:12])];
        if (!te[0]) ans.status = STATUS_NOT_PRESENT;
        else ans.phys_out = {8'd0, te[31:12], rq.linear_address[11:0]};
      end
      return ans;
    end
    if (rq.large_page) begin
      if (de[0] || rq.linear_address[21:0] != 0 || rq.phys_address[21:0] != 0) begin
        ans.status = STATUS_NO_LARGE;
        return ans;
      end
      high = '0;
      if (pse_on) begin
        m = int'(phys_width);
        if (m > 40) m = 40;
        if (m < 32) m = 32;
        keep = (9'd1 << (m - 32)) - 9'd1;
        high = rq.phys_address[39:32] & keep[7:0];
      end
      dir_mirror[rq.linear_address[31:22]] = flags | 32'h80 | {23'd0, rq.global_page, 8'd0}
          | {19'd0, rq.attribute_table, 12'd0} | {11'd0, high, 13'd0}
          | {rq.phys_address[31:22], 22'd0};
      return ans;
    end
    if (!de[0]) begin
      if (tables_used >= TABLE_COUNT) begin
        ans.status = STATUS_NO_TABLE;
        return ans;
      end
      tnum = 20'(tables_used);
      for (int i = 0; i < ENTRIES_PER_TABLE; i++)
        tbl_mirror[int'(tnum)*ENTRIES_PER_TABLE + i] = '0;
      dir_mirror[rq.linear_address[31:22]] = flags | {pool_base + tnum, 12'd0};
      tables_used++;
    end else if (de[7]) begin
      ans.status = STATUS_PRESENT;
      return ans;
    end else if (tnum >= TABLE_COUNT) begin
      ans.status = STATUS_NO_TABLE;
      return ans;
    end
    slot = int'(tnum)*ENTRIES_PER_TABLE + int'(rq.linear_address[21:12]);
    if (tbl_mirror[slot][0]) begin
      ans.status = STATUS_PRESENT;
      return ans;
    end
    tbl_mirror[slot] = flags | {24'd0, rq.attribute_table, 7'd0}
        | {23'd0, rq.global_page, 8'd0} | {rq.phys_address[31:12], 12'd0};
    return ans;
  endfunction

  // a new pool base must not turn any link into one on a table never allocated
  function automatic bit base_keeps_links(input logic [19:0] cand);
    logic [19:0] t;
    for (int i = 0; i < DIR_DEPTH; i++) begin
      t = dir_mirror[i][31:12] - cand;
      if (dir_mirror[i][0] && !dir_mirror[i][7] && t >= tables_used && t < TABLE_COUNT)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic request_t random_word();
    request_t    rq;
    logic [63:0] r;
    logic [6:0]  a;
    logic [32:0] m;
    r = {$urandom, $urandom};
    a = 7'($urandom_range(127));
    rq.phys_address = r[39:0];
    {rq.writable, rq.user_access, rq.write_through, rq.cache_disable, rq.large_page,
     rq.global_page, rq.attribute_table} = a;
    rq.linear_address = $urandom;
    if ($urandom_range(3) != 0) rq.linear_address[31:22] = hot_dir[$urandom_range(HOT_SLOTS-1)];
    if ($urandom_range(99) < 45) begin
      rq.command = CMD_TRANSLATE;
      if (mapped_lins.size() != 0 && $urandom_range(9) < 6) begin
        m = mapped_lins[$urandom_range(mapped_lins.size()-1)];
        if (m[32]) rq.linear_address[31:22] = m[31:22];
        else rq.linear_address[31:12] = m[31:12];
      end
    end else begin
      rq.command = CMD_MAP;
      rq.large_page = ($urandom_range(9) < 3);
      if (rq.large_page && $urandom_range(9) < 8) begin
        rq.linear_address[21:0] = '0;
        rq.phys_address[21:0] = '0;
      end
      if (mapped_lins.size() != 0 && $urandom_range(9) == 0) begin
        m = mapped_lins[$urandom_range(mapped_lins.size()-1)];
        rq.linear_address = m[31:0];
      end
    end
    return rq;
  endfunction

  task automatic send_word(input request_t rq, input bit typed, input result_t typed_ans,
                           input int idle_pct);
    result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = walk_or_map(rq);
    answers_due.push_back(typed ? typed_ans : predicted);
    if (rq.command == CMD_MAP && predicted.status == STATUS_OK)
      mapped_lins.push_back({rq.large_page, rq.linear_address});
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PSE36:      pse_on = val[0];
      CFG_MAX_PHYS:   phys_width = val[5:0];
      CFG_TABLE_BASE: pool_base = val[19:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    // drop start while the last word is still being worked on
    @(negedge clk);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (answers_due.size() == 0) begin
        $error("unexpected word: status %0d phys_out %h", result.status, result.phys_out);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          fail_count++;
        end
        if (result.phys_out !== want.phys_out) begin
          $error("phys_out: expected %h, got %h", want.phys_out, result.phys_out);
          fail_count++;
        end
      end
    end
  end

  // counts cycles with no word moving in either direction
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("two_level_page_table_map_walk_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t   row;
    result_t     typed_ans;
    logic [19:0] next_base;
    for (int i = 0; i < DIR_DEPTH; i++) dir_mirror[i] = '0;
    for (int i = 0; i < TABLE_COUNT*ENTRIES_PER_TABLE; i++) tbl_mirror[i] = '0;
    tables_used = 0;
    pse_on = 1'b0;
    phys_width = 6'd32;
    pool_base = '0;
    for (int i = 0; i < HOT_SLOTS; i++) hot_dir[i] = 10'($urandom_range(DIR_DEPTH-1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int pass = 0; pass < 4; pass++) begin
      if (pass > 0) drain();
      // directory empty at the start, so any base is safe there
      next_base = (pass == 0) ? 20'hFFFFF : pool_base + PASS_STEP[pass];
      if (!base_keeps_links(next_base)) next_base = pool_base;
      write_reg(CFG_PSE36, {19'd0, PASS_PSE[pass]});
      write_reg(CFG_MAX_PHYS, {14'd0, PASS_WIDE[pass]});
      write_reg(CFG_TABLE_BASE, next_base);
      @(negedge clk);
      cfg_write_enable <= 1'b0;

      if (pass == 0) begin
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
          row = DIRECTED[i];
          typed_ans.status = row.st;
          typed_ans.phys_out = row.phys;
          send_word(request_t'({row.cmd, row.lin, row.pa, row.attr}), row.typed, typed_ans,
                    PASS_IDLE[pass]);
        end
      end
      typed_ans = '0;
      for (int i = 0; i < RANDOM_PER_PASS; i++)
        send_word(random_word(), 1'b0, typed_ans, PASS_IDLE[pass]);
    end
    @(negedge clk);
    start <= 1'b0;
    drain();

    if (fail_count == 0) begin
      $display("two_level_page_table_map_walk_unit test passed");
    end else begin
      $display("two_level_page_table_map_walk_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tlpt_pkg.sv
src/tlpt_ram.sv
src/two_level_page_table_map_walk_unit.sv
src/tlpt_checker.sv
dv/tb_two_level_page_table_map_walk_unit.sv
